// ===== rtl/lfit_pkg.sv =====
// Shared types, codes and sizes of the LIN frame ID table.
package lfit_pkg;

   localparam int DefaultTableDepth = 16;

   localparam int KindW   = 3;
   localparam int IdW     = 8;
   localparam int SizeW   = 4;
   localparam int StatusW = 3;
   localparam int ActionW = 2;
   localparam int LenW    = 4;
   localparam int FreeW   = 5;

   localparam logic [IdW-1:0]   ID_MAX  = 8'h3F;
   localparam logic [SizeW-1:0] LEN_MAX = 4'd8;
   localparam logic [SizeW-1:0] LEN_MIN = 4'd1;
   localparam logic [FreeW-1:0] FREE_SAT = 5'd31;

   // item kinds
   localparam logic [KindW-1:0] KIND_HEADER     = 3'd0;
   localparam logic [KindW-1:0] KIND_RX_FRAME   = 3'd1;
   localparam logic [KindW-1:0] KIND_SCHEDULE   = 3'd2;
   localparam logic [KindW-1:0] KIND_REGISTER   = 3'd3;
   localparam logic [KindW-1:0] KIND_UNREGISTER = 3'd4;

   // result status
   localparam logic [StatusW-1:0] ST_OK       = 3'd0;
   localparam logic [StatusW-1:0] ST_INVALID  = 3'd1;
   localparam logic [StatusW-1:0] ST_FULL     = 3'd2;
   localparam logic [StatusW-1:0] ST_EXISTS   = 3'd3;
   localparam logic [StatusW-1:0] ST_NOTSUP   = 3'd4;
   localparam logic [StatusW-1:0] ST_MISMATCH = 3'd5;

   // requested bus action
   localparam logic [ActionW-1:0] ACT_NONE = 2'd0;
   localparam logic [ActionW-1:0] ACT_RECV = 2'd1;
   localparam logic [ActionW-1:0] ACT_SEND = 2'd2;

   // one stored table entry, 11 bits
   typedef struct packed {
      logic            outgoing;
      logic [LenW-1:0] len;
      logic [5:0]      id;
   } entry_type;

   localparam int EntryW = $bits(entry_type);

   // result word minus the free slot count
   typedef struct packed {
      logic [StatusW-1:0] status;
      logic [ActionW-1:0] action;
      logic [LenW-1:0]    rlen;
      logic               deliver;
   } result_type;

endpackage

// ===== rtl/lin_frame_id_table_core.sv =====
// Top level of the LIN frame ID table: command decode, table walk and result word.
//
// Usage
//   Input channel: drive req_* with start high; the word is taken at a rising
//   edge where start is high and busy is low. busy stays high while the table
//   is walked or compacted, so only one word is in flight at a time.
//   Result channel: rsp_valid is high for exactly one cycle with the rsp_*
//   fields. The receiver cannot stall; every accepted word yields exactly one
//   result word. The next word may be offered in the same cycle as rsp_valid.
//   Configuration: csr_write_en loads commander_mode; write it only when idle.
// Walk
//   Words settled by their fields alone (bad kind, receive error, bad
//   schedule or register arguments, full table, schedule outside commander
//   mode) give their result in the cycle after acceptance. All others walk
//   the table held in one RAM with registered read, one entry per cycle;
//   a match ends the walk early. An unregister moves later entries down
//   one per cycle.
// Reset
//   Synchronous reset empties the table (entry count to zero) and clears
//   commander mode; RAM contents are left as they are and only read below
//   the fill count.
module lin_frame_id_table_core #(
   parameter int TABLE_DEPTH = lfit_pkg::DefaultTableDepth
) (
   input  logic                          clock,
   input  logic                          reset,
   // input channel
   input  logic                          start,
   output logic                          busy,
   input  logic [lfit_pkg::KindW-1:0]    req_kind,
   input  logic [lfit_pkg::IdW-1:0]      req_ident,
   input  logic [lfit_pkg::SizeW-1:0]    req_data_len,
   input  logic                          req_outgoing_dir,
   input  logic                          req_payload_ready,
   input  logic                          req_rx_error,
   input  logic [lfit_pkg::LenW-1:0]     req_rx_length,
   // result channel
   output logic                          rsp_valid,
   output logic [lfit_pkg::StatusW-1:0]  rsp_status,
   output logic [lfit_pkg::ActionW-1:0]  rsp_action,
   output logic [lfit_pkg::LenW-1:0]     rsp_response_length,
   output logic                          rsp_deliver_frame,
   output logic [lfit_pkg::FreeW-1:0]    rsp_slots_left,
   // configuration
   input  logic                          csr_write_en,
   input  logic                          csr_write_data
);

   // index into the table, fill count, and a width wide enough for sums
   localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
   localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
   localparam int W     = (CNT_W + 1 > 6) ? CNT_W + 1 : 6;

   localparam logic [1:0] S_IDLE  = 2'd0;
   localparam logic [1:0] S_SCAN  = 2'd1;
   localparam logic [1:0] S_SHIFT = 2'd2;

   logic [1:0]                   state_ff, state_in;
   logic [CNT_W-1:0]             count_ff, count_in;
   logic                         cmdr_ff;

   // latched item fields
   logic [lfit_pkg::KindW-1:0]   kind_ff;
   logic [lfit_pkg::IdW-1:0]     id_ff;
   logic [lfit_pkg::SizeW-1:0]   size_ff;
   logic                         dir_ff;
   logic                         ready_ff;
   logic [lfit_pkg::LenW-1:0]    rxlen_ff;

   // walk pointers
   logic [CNT_W-1:0]             scan_idx_ff, scan_idx_in;
   logic [IDX_W-1:0]             cmp_idx_ff, cmp_idx_in;
   logic                         cmp_vld_ff, cmp_vld_in;
   logic [IDX_W-1:0]             wr_idx_ff, wr_idx_in;

   // result word
   logic                         rsp_valid_ff;
   lfit_pkg::result_type         res_ff, res;
   logic [lfit_pkg::FreeW-1:0]   free_ff, free_in;
   logic                         fin;

   // RAM port
   logic                         ram_wr_en, ram_rd_en;
   logic [IDX_W-1:0]             ram_wr_addr, ram_rd_addr;
   lfit_pkg::entry_type          ram_wr_data, entry;

   logic                         accept;
   logic                         hit;
   logic [W-1:0]                 free_w;

   assign busy   = (state_ff != S_IDLE);
   assign accept = start && !busy;
   assign hit    = cmp_vld_ff && ({2'b00, entry.id} == id_ff);

   lfit_ram #(
      .WIDTH (lfit_pkg::EntryW),
      .DEPTH (TABLE_DEPTH),
      .AW    (IDX_W)
   ) u_table (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (entry)
   );

   always_comb begin
      state_in    = state_ff;
      count_in    = count_ff;
      scan_idx_in = scan_idx_ff;
      cmp_idx_in  = cmp_idx_ff;
      cmp_vld_in  = cmp_vld_ff;
      wr_idx_in   = wr_idx_ff;
      ram_wr_en   = 1'b0;
      ram_wr_addr = '0;
      ram_wr_data = '0;
      ram_rd_en   = 1'b0;
      ram_rd_addr = '0;
      fin         = 1'b0;
      res         = '{status: lfit_pkg::ST_INVALID, action: lfit_pkg::ACT_NONE,
                      rlen: '0, deliver: 1'b0};

      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               // settle what the fields alone decide, else start the walk
               if (req_kind > lfit_pkg::KIND_UNREGISTER) begin
                  fin = 1'b1;
               end else if (req_kind == lfit_pkg::KIND_RX_FRAME && req_rx_error) begin
                  fin = 1'b1;
               end else if (req_kind == lfit_pkg::KIND_SCHEDULE &&
                            req_ident > lfit_pkg::ID_MAX) begin
                  fin = 1'b1;
               end else if (req_kind == lfit_pkg::KIND_SCHEDULE && !cmdr_ff) begin
                  fin        = 1'b1;
                  res.status = lfit_pkg::ST_NOTSUP;
               end else if (req_kind == lfit_pkg::KIND_REGISTER &&
                            (req_ident > lfit_pkg::ID_MAX ||
                             req_data_len < lfit_pkg::LEN_MIN ||
                             req_data_len > lfit_pkg::LEN_MAX)) begin
                  fin = 1'b1;
               end else if (req_kind == lfit_pkg::KIND_REGISTER &&
                            W'(count_ff) >= W'(TABLE_DEPTH)) begin
                  fin        = 1'b1;
                  res.status = lfit_pkg::ST_FULL;
               end else begin
                  state_in    = S_SCAN;
                  scan_idx_in = '0;
                  cmp_vld_in  = 1'b0;
               end
            end
         end

         S_SCAN: begin
            if (hit) begin
               // first entry with this ID found at cmp_idx_ff
               case (kind_ff)
                  lfit_pkg::KIND_HEADER, lfit_pkg::KIND_SCHEDULE: begin
                     fin        = 1'b1;
                     res.status = lfit_pkg::ST_OK;
                     res.rlen   = entry.len;
                     if (!entry.outgoing) begin
                        res.action = lfit_pkg::ACT_RECV;
                     end else if (ready_ff) begin
                        res.action = lfit_pkg::ACT_SEND;
                     end
                  end
                  lfit_pkg::KIND_RX_FRAME: begin
                     fin = 1'b1;
                     if (!entry.outgoing) begin
                        res.rlen = entry.len;
                        if (entry.len != rxlen_ff) begin
                           res.status = lfit_pkg::ST_MISMATCH;
                        end else begin
                           res.status  = lfit_pkg::ST_OK;
                           res.deliver = 1'b1;
                        end
                     end
                  end
                  lfit_pkg::KIND_REGISTER: begin
                     fin        = 1'b1;
                     res.status = lfit_pkg::ST_EXISTS;
                  end
                  default: begin
                     // unregister: drop the last entry outright, else compact
                     if (W'(cmp_idx_ff) + W'(1) >= W'(count_ff)) begin
                        fin        = 1'b1;
                        res.status = lfit_pkg::ST_OK;
                        count_in   = count_ff - CNT_W'(1);
                     end else begin
                        state_in    = S_SHIFT;
                        wr_idx_in   = cmp_idx_ff;
                        ram_rd_en   = 1'b1;
                        ram_rd_addr = IDX_W'(W'(cmp_idx_ff) + W'(1));
                     end
                  end
               endcase
               if (fin) begin
                  state_in = S_IDLE;
               end
            end else if (scan_idx_ff < count_ff) begin
               // issue the next read; compare it in the next cycle
               ram_rd_en   = 1'b1;
               ram_rd_addr = scan_idx_ff[IDX_W-1:0];
               cmp_idx_in  = scan_idx_ff[IDX_W-1:0];
               cmp_vld_in  = 1'b1;
               scan_idx_in = scan_idx_ff + CNT_W'(1);
            end else if (cmp_vld_ff) begin
               // last compare missed; finish in the next cycle
               cmp_vld_in = 1'b0;
            end else begin
               fin      = 1'b1;
               state_in = S_IDLE;
               if (kind_ff == lfit_pkg::KIND_REGISTER) begin
                  // append at the fill count
                  ram_wr_en            = 1'b1;
                  ram_wr_addr          = count_ff[IDX_W-1:0];
                  ram_wr_data.outgoing = dir_ff;
                  ram_wr_data.len      = size_ff;
                  ram_wr_data.id       = id_ff[5:0];
                  count_in             = count_ff + CNT_W'(1);
                  res.status           = lfit_pkg::ST_OK;
               end
            end
         end

         S_SHIFT: begin
            // move entry wr_idx+1 down to wr_idx, reading two ahead
            ram_wr_en   = 1'b1;
            ram_wr_addr = wr_idx_ff;
            ram_wr_data = entry;
            if (W'(wr_idx_ff) + W'(2) >= W'(count_ff)) begin
               fin        = 1'b1;
               res.status = lfit_pkg::ST_OK;
               count_in   = count_ff - CNT_W'(1);
               state_in   = S_IDLE;
            end else begin
               ram_rd_en   = 1'b1;
               ram_rd_addr = IDX_W'(W'(wr_idx_ff) + W'(2));
               wr_idx_in   = IDX_W'(W'(wr_idx_ff) + W'(1));
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // free slots after this word, saturated
   assign free_w  = W'(TABLE_DEPTH) - W'(count_in);
   assign free_in = (free_w > W'(lfit_pkg::FREE_SAT)) ? lfit_pkg::FREE_SAT
                                                      : free_w[lfit_pkg::FreeW-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         cmdr_ff      <= 1'b0;
         cmp_vld_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         cmp_vld_ff   <= cmp_vld_in;
         rsp_valid_ff <= fin;
         if (csr_write_en) begin
            cmdr_ff <= csr_write_data;
         end
      end
   end

   // payload: no reset
   always_ff @(posedge clock) begin
      scan_idx_ff <= scan_idx_in;
      cmp_idx_ff  <= cmp_idx_in;
      wr_idx_ff   <= wr_idx_in;
      if (accept) begin
         kind_ff  <= req_kind;
         id_ff    <= req_ident;
         size_ff  <= req_data_len;
         dir_ff   <= req_outgoing_dir;
         ready_ff <= req_payload_ready;
         rxlen_ff <= req_rx_length;
      end
      if (fin) begin
         res_ff  <= res;
         free_ff <= free_in;
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_status          = res_ff.status;
   assign rsp_action          = res_ff.action;
   assign rsp_response_length = res_ff.rlen;
   assign rsp_deliver_frame   = res_ff.deliver;
   assign rsp_slots_left      = free_ff;

   // fill count never passes the table size
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      W'(count_ff) <= W'(TABLE_DEPTH))
      else $error("entry count beyond table depth");

   // reported free slots agree with the fill count left behind
   a_free_match: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (W'(rsp_slots_left) ==
         ((W'(TABLE_DEPTH) - W'(count_ff) > W'(lfit_pkg::FREE_SAT)) ?
            W'(lfit_pkg::FREE_SAT) : W'(TABLE_DEPTH) - W'(count_ff))))
      else $error("free slot count disagrees with entry count");

   // an accepted word either answers at once or keeps the block busy
   a_accept_progress: assert property (@(posedge clock) disable iff (reset)
      accept |=> (rsp_valid_ff || busy))
      else $error("accepted word neither answered nor in progress");

   // compaction only ever writes inside the valid part of the table
   a_shift_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_SHIFT) |-> (W'(wr_idx_ff) + W'(1) < W'(count_ff)))
      else $error("compaction beyond the last entry");

   // a bus action is only requested with an ok status
   a_action_ok: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_action != lfit_pkg::ACT_NONE) |-> (rsp_status == lfit_pkg::ST_OK))
      else $error("action requested with failing status");

endmodule

// ===== rtl/lfit_ram.sv =====
// Generic simple dual-port RAM with registered read.
module lfit_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
